### hdl/mcr_pkg.sv
// mcr_pkg: shared constants and types of the midpoint circle rasterizer
// no dependencies

package mcr_pkg;

  // default coordinate width of center, radius and offset fields
  localparam int CoordBitsDef = 12;

  // points emitted for one octant step
  localparam int PointsPerStep = 8;
  localparam int PointIdxW     = $clog2(PointsPerStep);

  // attribute widths
  localparam int ColorW = 32;
  localparam int AlphaW = 8;
  localparam int LayerW = 8;

  // item kind carried on the input tuser
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } opcode_e;

endpackage

### hdl/mcr_walker.sv
// mcr_walker: octant walker state of the midpoint circle rasterizer
// holds the latched circle and runs the error updates of one step per cycle; a live step waits for a free job slot
// depends on mcr_pkg

module mcr_walker #(
  parameter int COORD_BITS = mcr_pkg::CoordBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // registered input item
  input  logic                             item_valid_i,
  output logic                             item_ready_o,
  input  mcr_pkg::opcode_e                 opcode_i,
  input  logic [COORD_BITS-1:0]            center_row_i,
  input  logic [COORD_BITS-1:0]            center_col_i,
  input  logic [COORD_BITS-1:0]            radius_i,
  input  logic [COORD_BITS-1:0]            row_offset_i,
  input  logic [COORD_BITS-1:0]            col_offset_i,
  input  logic [mcr_pkg::ColorW-1:0]       color_i,
  input  logic [mcr_pkg::AlphaW-1:0]       alpha_i,
  input  logic [mcr_pkg::LayerW-1:0]       layer_i,
  // step job toward the emitter
  output logic                             job_valid_o,
  input  logic                             job_ready_i,
  output logic [COORD_BITS:0]              job_x_o,
  output logic [COORD_BITS:0]              job_y_o,
  output logic [COORD_BITS+1:0]            job_base_row_o,
  output logic [COORD_BITS+1:0]            job_base_col_o,
  output logic [mcr_pkg::ColorW-1:0]       job_color_o,
  output logic [mcr_pkg::AlphaW-1:0]       job_alpha_o,
  output logic [mcr_pkg::LayerW-1:0]       job_layer_o,
  output logic                             job_done_o
);
  import mcr_pkg::*;

  localparam int PosW  = COORD_BITS + 1;
  localparam int StepW = COORD_BITS + 2;
  localparam int ErrW  = COORD_BITS + 4;
  localparam int BaseW = COORD_BITS + 2;

  logic [PosW-1:0]   pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [StepW-1:0]  step_dx_q, step_dx_d, step_dy_q, step_dy_d;
  logic [ErrW-1:0]   err_q, err_d;
  logic [PosW-1:0]   diam_q, diam_d;
  logic [BaseW-1:0]  base_row_q, base_row_d, base_col_q, base_col_d;
  logic [ColorW-1:0] color_q, color_d;
  logic [AlphaW-1:0] alpha_q, alpha_d;
  logic [LayerW-1:0] layer_q, layer_d;

  logic              active;
  logic              is_step;
  logic              take;
  logic [PosW-1:0]   y1, x2;
  logic [StepW-1:0]  dy1, dx2;
  logic [ErrW-1:0]   err1, err2;

  // walker is still on the outline while x >= y
  assign active  = !($signed(pos_x_q) < $signed(pos_y_q));
  assign is_step = (opcode_i == OP_STEP);

  // first update: move along y while the error is not positive
  always_comb begin
    y1   = pos_y_q;
    err1 = err_q;
    dy1  = step_dy_q;
    if ($signed(err_q) <= 0) begin
      y1   = pos_y_q + PosW'(1);
      err1 = err_q + {{(ErrW-StepW){1'b0}}, step_dy_q};
      dy1  = step_dy_q + StepW'(2);
    end
  end

  // second update: step x inward once the error turns positive
  always_comb begin
    x2   = pos_x_q;
    err2 = err1;
    dx2  = step_dx_q;
    if ($signed(err1) > 0) begin
      x2   = pos_x_q - PosW'(1);
      dx2  = step_dx_q + StepW'(2);
      err2 = err1 + {{(ErrW-StepW){1'b0}}, dx2} - {{(ErrW-PosW){1'b0}}, diam_q};
    end
  end

  // loads and finished steps never wait; live steps need a free job slot
  assign item_ready_o = !is_step || !active || job_ready_i;
  assign take         = item_valid_i && item_ready_o;
  assign job_valid_o  = item_valid_i && is_step && active;

  // job payload: current point and latched attributes
  assign job_x_o        = pos_x_q;
  assign job_y_o        = pos_y_q;
  assign job_base_row_o = base_row_q;
  assign job_base_col_o = base_col_q;
  assign job_color_o    = color_q;
  assign job_alpha_o    = alpha_q;
  assign job_layer_o    = layer_q;
  assign job_done_o     = $signed(x2) < $signed(y1);

  // next state of the walker
  always_comb begin
    pos_x_d    = pos_x_q;
    pos_y_d    = pos_y_q;
    step_dx_d  = step_dx_q;
    step_dy_d  = step_dy_q;
    err_d      = err_q;
    diam_d     = diam_q;
    base_row_d = base_row_q;
    base_col_d = base_col_q;
    color_d    = color_q;
    alpha_d    = alpha_q;
    layer_d    = layer_q;
    if (take) begin
      if (!is_step) begin
        diam_d     = {radius_i, 1'b0};
        pos_x_d    = {1'b0, radius_i} - PosW'(1);
        pos_y_d    = '0;
        step_dx_d  = StepW'(1);
        step_dy_d  = StepW'(1);
        err_d      = ErrW'(1) - {{(ErrW-PosW){1'b0}}, radius_i, 1'b0};
        base_row_d = {2'b00, row_offset_i} + {2'b00, center_row_i};
        base_col_d = {2'b00, col_offset_i} + {2'b00, center_col_i};
        color_d    = color_i;
        alpha_d    = alpha_i;
        layer_d    = layer_i;
      end else if (active) begin
        pos_x_d   = x2;
        pos_y_d   = y1;
        step_dx_d = dx2;
        step_dy_d = dy1;
        err_d     = err2;
      end
    end
  end

  // walker state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q    <= '0;
      pos_y_q    <= '0;
      step_dx_q  <= StepW'(1);
      step_dy_q  <= StepW'(1);
      err_q      <= '0;
      diam_q     <= '0;
      base_row_q <= '0;
      base_col_q <= '0;
      color_q    <= '0;
      alpha_q    <= '0;
      layer_q    <= '0;
    end else begin
      pos_x_q    <= pos_x_d;
      pos_y_q    <= pos_y_d;
      step_dx_q  <= step_dx_d;
      step_dy_q  <= step_dy_d;
      err_q      <= err_d;
      diam_q     <= diam_d;
      base_row_q <= base_row_d;
      base_col_q <= base_col_d;
      color_q    <= color_d;
      alpha_q    <= alpha_d;
      layer_q    <= layer_d;
    end
  end

endmodule

### hdl/mcr_emitter.sv
// mcr_emitter: holds one step job and sends its eight symmetric points
// through a registered output stage, one point per cycle while the receiver is ready
// depends on mcr_pkg

module mcr_emitter #(
  parameter int COORD_BITS = mcr_pkg::CoordBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // step job from the walker
  input  logic                             job_valid_i,
  output logic                             job_ready_o,
  input  logic [COORD_BITS:0]              job_x_i,
  input  logic [COORD_BITS:0]              job_y_i,
  input  logic [COORD_BITS+1:0]            job_base_row_i,
  input  logic [COORD_BITS+1:0]            job_base_col_i,
  input  logic [mcr_pkg::ColorW-1:0]       job_color_i,
  input  logic [mcr_pkg::AlphaW-1:0]       job_alpha_i,
  input  logic [mcr_pkg::LayerW-1:0]       job_layer_i,
  input  logic                             job_done_i,
  // registered point output
  output logic                             pix_valid_o,
  input  logic                             pix_ready_i,
  output logic [COORD_BITS+2:0]            pixel_row_o,
  output logic [COORD_BITS+2:0]            pixel_col_o,
  output logic [mcr_pkg::ColorW-1:0]       pixel_color_o,
  output logic [mcr_pkg::AlphaW-1:0]       pixel_alpha_o,
  output logic [mcr_pkg::LayerW-1:0]       pixel_layer_o,
  output logic                             last_of_step_o,
  output logic                             circle_done_o
);
  import mcr_pkg::*;

  localparam int PosW  = COORD_BITS + 1;
  localparam int BaseW = COORD_BITS + 2;
  localparam int OutW  = COORD_BITS + 3;

  // job holding register
  logic                 job_vld_q, job_vld_d;
  logic [PointIdxW-1:0] idx_q, idx_d;
  logic [PosW-1:0]      x_q, y_q;
  logic [BaseW-1:0]     brow_q, bcol_q;
  logic [ColorW-1:0]    color_q;
  logic [AlphaW-1:0]    alpha_q;
  logic [LayerW-1:0]    layer_q;
  logic                 done_q;

  // output register
  logic                 out_vld_q, out_vld_d;
  logic [OutW-1:0]      row_q, col_q;
  logic [ColorW-1:0]    ocolor_q;
  logic [AlphaW-1:0]    oalpha_q;
  logic [LayerW-1:0]    olayer_q;
  logic                 olast_q, odone_q;

  logic                 out_load;
  logic                 last_pt;
  logic                 job_take;
  logic [OutW-1:0]      xe, ye, nx, ny, drow, dcol, row_d, col_d;

  assign out_load    = job_vld_q && (!out_vld_q || pix_ready_i);
  assign last_pt     = (idx_q == PointIdxW'(PointsPerStep - 1));
  assign job_ready_o = !job_vld_q || (out_load && last_pt);
  assign job_take    = job_valid_i && job_ready_o;

  // sign-extended octant point and its negations
  assign xe = {{(OutW-PosW){x_q[PosW-1]}}, x_q};
  assign ye = {{(OutW-PosW){y_q[PosW-1]}}, y_q};
  assign nx = OutW'(0) - xe;
  assign ny = OutW'(0) - ye;

  // symmetric point order: (x,y) (y,x) (-y,x) (-x,y) (-x,-y) (-y,-x) (y,-x) (x,-y)
  always_comb begin
    case (idx_q)
      3'd0:    begin drow = xe; dcol = ye; end
      3'd1:    begin drow = ye; dcol = xe; end
      3'd2:    begin drow = ny; dcol = xe; end
      3'd3:    begin drow = nx; dcol = ye; end
      3'd4:    begin drow = nx; dcol = ny; end
      3'd5:    begin drow = ny; dcol = nx; end
      3'd6:    begin drow = ye; dcol = nx; end
      default: begin drow = xe; dcol = ny; end
    endcase
  end

  assign row_d = {{(OutW-BaseW){1'b0}}, brow_q} + drow;
  assign col_d = {{(OutW-BaseW){1'b0}}, bcol_q} + dcol;

  // job slot and point counter
  always_comb begin
    job_vld_d = job_vld_q;
    idx_d     = idx_q;
    if (out_load) begin
      idx_d = idx_q + PointIdxW'(1);
      if (last_pt) begin
        job_vld_d = 1'b0;
      end
    end
    if (job_take) begin
      job_vld_d = 1'b1;
      idx_d     = '0;
    end
  end

  // output stage valid
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (pix_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      job_vld_q <= job_vld_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  // job payload capture
  always_ff @(posedge clk_i) begin
    if (job_take) begin
      x_q     <= job_x_i;
      y_q     <= job_y_i;
      brow_q  <= job_base_row_i;
      bcol_q  <= job_base_col_i;
      color_q <= job_color_i;
      alpha_q <= job_alpha_i;
      layer_q <= job_layer_i;
      done_q  <= job_done_i;
    end
  end

  // output payload capture
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      row_q    <= row_d;
      col_q    <= col_d;
      ocolor_q <= color_q;
      oalpha_q <= alpha_q;
      olayer_q <= layer_q;
      olast_q  <= last_pt;
      odone_q  <= last_pt && done_q;
    end
  end

  assign pix_valid_o    = out_vld_q;
  assign pixel_row_o    = row_q;
  assign pixel_col_o    = col_q;
  assign pixel_color_o  = ocolor_q;
  assign pixel_alpha_o  = oalpha_q;
  assign pixel_layer_o  = olayer_q;
  assign last_of_step_o = olast_q;
  assign circle_done_o  = odone_q;

endmodule

### hdl/midpoint_circle_rasterizer_top.sv
// Midpoint circle outline rasterizer. A load item (tuser 0) latches center, radius,
// offsets and pixel attributes; each step item (tuser 1) emits the eight symmetric
// outline points of the current octant point, then advances the walker. A step after
// the outline is finished, and every load, emits nothing. A step that emits sends
// its points one per cycle through the single output register while the receiver
// is ready. One further item can wait in the input register while points are sent;
// a step that finds the emitter busy holds the input until the last point of the
// current step is loaded, so steps stream with no gaps on the output. With the
// emitter idle, the first point of a step passes from the input register through the
// job holding register into the output register before it is presented.
// depends on mcr_pkg, mcr_walker, mcr_emitter

module midpoint_circle_rasterizer_top #(
  parameter int  COORD_BITS = mcr_pkg::CoordBitsDef,
  localparam int InDataW  = ((5 * COORD_BITS + 48 + 7) / 8) * 8,
  localparam int OutDataW = ((2 * (COORD_BITS + 3) + 48 + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // center_row, center_col, radius, row_offset, col_offset, color, alpha, layer
  input  logic [InDataW-1:0]  s_axis_tdata,
  // opcode
  input  logic                s_axis_tuser,
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // pixel_row, pixel_col, pixel_color, pixel_alpha, pixel_layer
  output logic [OutDataW-1:0] m_axis_tdata,
  // last_of_step
  output logic                m_axis_tlast,
  // circle_done
  output logic                m_axis_tuser
);
  import mcr_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int OutW  = COORD_BITS + 3;
  localparam int OutRawW = 2 * OutW + ColorW + AlphaW + LayerW;

  // input register
  logic                in_vld_q, in_vld_d;
  opcode_e             op_q;
  logic [C-1:0]        crow_q, ccol_q, rad_q, roff_q, coff_q;
  logic [ColorW-1:0]   color_q;
  logic [AlphaW-1:0]   alpha_q;
  logic [LayerW-1:0]   layer_q;
  logic                in_take;

  // walker to emitter
  logic                item_ready;
  logic                job_valid, job_ready, job_done;
  logic [C:0]          job_x, job_y;
  logic [C+1:0]        job_brow, job_bcol;
  logic [ColorW-1:0]   job_color;
  logic [AlphaW-1:0]   job_alpha;
  logic [LayerW-1:0]   job_layer;

  // emitter outputs
  logic [OutW-1:0]     pix_row, pix_col;
  logic [ColorW-1:0]   pix_color;
  logic [AlphaW-1:0]   pix_alpha;
  logic [LayerW-1:0]   pix_layer;

  assign s_axis_tready = !in_vld_q || item_ready;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // input stage valid
  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (item_ready) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // unpack the transaction into the input register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q    <= opcode_e'(s_axis_tuser);
      crow_q  <= s_axis_tdata[C-1:0];
      ccol_q  <= s_axis_tdata[2*C-1:C];
      rad_q   <= s_axis_tdata[3*C-1:2*C];
      roff_q  <= s_axis_tdata[4*C-1:3*C];
      coff_q  <= s_axis_tdata[5*C-1:4*C];
      color_q <= s_axis_tdata[5*C+ColorW-1:5*C];
      alpha_q <= s_axis_tdata[5*C+ColorW+AlphaW-1:5*C+ColorW];
      layer_q <= s_axis_tdata[5*C+ColorW+AlphaW+LayerW-1:5*C+ColorW+AlphaW];
    end
  end

  mcr_walker #(
    .COORD_BITS (COORD_BITS)
  ) u_walker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (in_vld_q),
    .item_ready_o   (item_ready),
    .opcode_i       (op_q),
    .center_row_i   (crow_q),
    .center_col_i   (ccol_q),
    .radius_i       (rad_q),
    .row_offset_i   (roff_q),
    .col_offset_i   (coff_q),
    .color_i        (color_q),
    .alpha_i        (alpha_q),
    .layer_i        (layer_q),
    .job_valid_o    (job_valid),
    .job_ready_i    (job_ready),
    .job_x_o        (job_x),
    .job_y_o        (job_y),
    .job_base_row_o (job_brow),
    .job_base_col_o (job_bcol),
    .job_color_o    (job_color),
    .job_alpha_o    (job_alpha),
    .job_layer_o    (job_layer),
    .job_done_o     (job_done)
  );

  mcr_emitter #(
    .COORD_BITS (COORD_BITS)
  ) u_emitter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_ready_o    (job_ready),
    .job_x_i        (job_x),
    .job_y_i        (job_y),
    .job_base_row_i (job_brow),
    .job_base_col_i (job_bcol),
    .job_color_i    (job_color),
    .job_alpha_i    (job_alpha),
    .job_layer_i    (job_layer),
    .job_done_i     (job_done),
    .pix_valid_o    (m_axis_tvalid),
    .pix_ready_i    (m_axis_tready),
    .pixel_row_o    (pix_row),
    .pixel_col_o    (pix_col),
    .pixel_color_o  (pix_color),
    .pixel_alpha_o  (pix_alpha),
    .pixel_layer_o  (pix_layer),
    .last_of_step_o (m_axis_tlast),
    .circle_done_o  (m_axis_tuser)
  );

  // pack the output transaction, zero padded to whole bytes
  assign m_axis_tdata = {{(OutDataW-OutRawW){1'b0}},
                         pix_layer, pix_alpha, pix_color, pix_col, pix_row};

  // done flag only on the closing point of a step
  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("circle_done without last_of_step");

  // input side stalls only while an item waits in the input register
  a_stall_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_vld_q)
    else $error("input stalled with empty input register");

  // a step that emits is consumed only when the emitter takes its job
  a_step_to_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && item_ready && job_valid |-> job_ready)
    else $error("emitting step consumed without job slot");

  // a job handed over has a point on offer after the job holding and output registers
  a_job_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid && job_ready |=> ##1 m_axis_tvalid)
    else $error("job accepted but no point loaded");

endmodule

### tb/tb_midpoint_circle_rasterizer_top.sv
// tb_midpoint_circle_rasterizer_top: self-checking testbench of the midpoint circle rasterizer
// predicts every outline pixel from a local walker model and checks the output stream
// depends on mcr_pkg and midpoint_circle_rasterizer_top

`timescale 1ns / 100ps

module tb_midpoint_circle_rasterizer_top;
  import mcr_pkg::*;

  localparam int CoordBits   = CoordBitsDef;
  localparam int InDataW     = ((5 * CoordBits + 48 + 7) / 8) * 8;
  localparam int OutDataW    = ((2 * (CoordBits + 3) + 48 + 7) / 8) * 8;
  localparam int PixW        = CoordBits + 3;
  localparam int ClkPeriod   = 10;
  localparam int LongHold    = 300;
  localparam int LimitCycles = 400_000;

  // input tdata field positions
  localparam int CrowLsb  = 0;
  localparam int CcolLsb  = CrowLsb + CoordBits;
  localparam int RadLsb   = CcolLsb + CoordBits;
  localparam int RoffLsb  = RadLsb + CoordBits;
  localparam int CoffLsb  = RoffLsb + CoordBits;
  localparam int ColorLsb = CoffLsb + CoordBits;
  localparam int AlphaLsb = ColorLsb + ColorW;
  localparam int LayerLsb = AlphaLsb + AlphaW;

  // output tdata field positions
  localparam int RowLsb    = 0;
  localparam int ColLsb    = RowLsb + PixW;
  localparam int PColorLsb = ColLsb + PixW;
  localparam int PAlphaLsb = PColorLsb + ColorW;
  localparam int PLayerLsb = PAlphaLsb + AlphaW;

  typedef struct {
    opcode_e               op;
    logic [CoordBits-1:0]  center_row;
    logic [CoordBits-1:0]  center_col;
    logic [CoordBits-1:0]  radius;
    logic [CoordBits-1:0]  row_offset;
    logic [CoordBits-1:0]  col_offset;
    logic [ColorW-1:0]     color;
    logic [AlphaW-1:0]     alpha;
    logic [LayerW-1:0]     layer;
  } circle_item_t;

  typedef struct {
    logic [PixW-1:0]   row;
    logic [PixW-1:0]   col;
    logic [ColorW-1:0] color;
    logic [AlphaW-1:0] alpha;
    logic [LayerW-1:0] layer;
    logic              last_of_step;
    logic              circle_done;
  } pixel_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tuser;

  pixel_t pixel_q[$];
  int     mismatches = 0;
  int     items_sent = 0;
  bit     src_gaps   = 1'b0;
  bit     sink_gaps  = 1'b0;
  int     hold_req   = 0;
  int     hold_ack   = 0;
  int     stall_left = 0;

  // walker model state
  logic signed [CoordBits:0]   walk_x    = '0;
  logic signed [CoordBits:0]   walk_y    = '0;
  logic [CoordBits+1:0]        walk_dx   = (CoordBits+2)'(1);
  logic [CoordBits+1:0]        walk_dy   = (CoordBits+2)'(1);
  logic signed [CoordBits+3:0] walk_err  = '0;
  logic [CoordBits:0]          walk_diam = '0;
  logic [CoordBits+1:0]        org_row   = '0;
  logic [CoordBits+1:0]        org_col   = '0;
  logic [ColorW-1:0]           lat_color = '0;
  logic [AlphaW-1:0]           lat_alpha = '0;
  logic [LayerW-1:0]           lat_layer = '0;

  midpoint_circle_rasterizer_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  // clock
  always begin
    #(ClkPeriod / 2) clk_i = 1'b1;
    #(ClkPeriod / 2) clk_i = 1'b0;
  end

  // run limit
  initial begin
    #(LimitCycles * ClkPeriod);
    $display("tb_midpoint_circle_rasterizer_top failed");
    $finish;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches < 40) begin
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  // expected pixels of one accepted transaction
  task automatic rasterize_item(opcode_e op, logic [InDataW-1:0] d);
    logic [CoordBits-1:0] r;
    int     xi;
    int     yi;
    int     drow[8];
    int     dcol[8];
    bit     outline_done;
    pixel_t px;
    r = d[RadLsb +: CoordBits];
    if (op == OP_LOAD) begin
      walk_diam = {r, 1'b0};
      walk_x    = {1'b0, r} - 1'b1;
      walk_y    = '0;
      walk_dx   = (CoordBits+2)'(1);
      walk_dy   = (CoordBits+2)'(1);
      walk_err  = (CoordBits+4)'(1) - (CoordBits+4)'({r, 1'b0});
      org_row   = {2'b00, d[RoffLsb +: CoordBits]} + {2'b00, d[CrowLsb +: CoordBits]};
      org_col   = {2'b00, d[CoffLsb +: CoordBits]} + {2'b00, d[CcolLsb +: CoordBits]};
      lat_color = d[ColorLsb +: ColorW];
      lat_alpha = d[AlphaLsb +: AlphaW];
      lat_layer = d[LayerLsb +: LayerW];
    end else if (walk_x >= walk_y) begin
      xi   = int'(walk_x);
      yi   = int'(walk_y);
      drow = '{xi, yi, -yi, -xi, -xi, -yi, yi, xi};
      dcol = '{yi, xi, xi, yi, -yi, -xi, -xi, -yi};
      // two sequential error updates
      if (walk_err <= 0) begin
        walk_y   = walk_y + 1'b1;
        walk_err = walk_err + $signed({2'b00, walk_dy});
        walk_dy  = walk_dy + 2'd2;
      end
      if (walk_err > 0) begin
        walk_x   = walk_x - 1'b1;
        walk_dx  = walk_dx + 2'd2;
        walk_err = walk_err + $signed({2'b00, walk_dx}) - $signed({3'b000, walk_diam});
      end
      outline_done = walk_x < walk_y;
      for (int k = 0; k < PointsPerStep; k++) begin
        px.row          = PixW'(int'(org_row) + drow[k]);
        px.col          = PixW'(int'(org_col) + dcol[k]);
        px.color        = lat_color;
        px.alpha        = lat_alpha;
        px.layer        = lat_layer;
        px.last_of_step = (k == PointsPerStep - 1);
        px.circle_done  = (k == PointsPerStep - 1) && outline_done;
        pixel_q.push_back(px);
      end
    end
  endtask

  task automatic check_pixel(logic [OutDataW-1:0] d, logic last, logic done);
    pixel_t want;
    if (pixel_q.size() == 0) begin
      report_mismatch("pixel with none expected", d[63:0], '0);
    end else begin
      want = pixel_q.pop_front();
      if (d[RowLsb +: PixW] !== want.row)
        report_mismatch("pixel_row", 64'(d[RowLsb +: PixW]), 64'(want.row));
      if (d[ColLsb +: PixW] !== want.col)
        report_mismatch("pixel_col", 64'(d[ColLsb +: PixW]), 64'(want.col));
      if (d[PColorLsb +: ColorW] !== want.color)
        report_mismatch("pixel_color", 64'(d[PColorLsb +: ColorW]), 64'(want.color));
      if (d[PAlphaLsb +: AlphaW] !== want.alpha)
        report_mismatch("pixel_alpha", 64'(d[PAlphaLsb +: AlphaW]), 64'(want.alpha));
      if (d[PLayerLsb +: LayerW] !== want.layer)
        report_mismatch("pixel_layer", 64'(d[PLayerLsb +: LayerW]), 64'(want.layer));
      if (last !== want.last_of_step)
        report_mismatch("last_of_step", 64'(last), 64'(want.last_of_step));
      if (done !== want.circle_done)
        report_mismatch("circle_done", 64'(done), 64'(want.circle_done));
    end
  endtask

  // predict on input transactions, check output transactions
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        rasterize_item(opcode_e'(s_axis_tuser), s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_pixel(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end
    end
  end

  // receiver: random stall bursts and requested long hold-offs
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack      <= hold_ack + 1;
      stall_left    <= LongHold - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(0, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [InDataW-1:0] pack_item(circle_item_t it);
    logic [InDataW-1:0] d;
    d = '0;
    d[CrowLsb +: CoordBits]  = it.center_row;
    d[CcolLsb +: CoordBits]  = it.center_col;
    d[RadLsb +: CoordBits]   = it.radius;
    d[RoffLsb +: CoordBits]  = it.row_offset;
    d[CoffLsb +: CoordBits]  = it.col_offset;
    d[ColorLsb +: ColorW]    = it.color;
    d[AlphaLsb +: AlphaW]    = it.alpha;
    d[LayerLsb +: LayerW]    = it.layer;
    return d;
  endfunction

  function automatic circle_item_t rand_item(opcode_e op, int rmin, int rmax);
    circle_item_t it;
    it.op         = op;
    it.center_row = CoordBits'($urandom_range(0, 4095));
    it.center_col = CoordBits'($urandom_range(0, 4095));
    it.radius     = CoordBits'($urandom_range(rmin, rmax));
    it.row_offset = CoordBits'($urandom_range(0, 4095));
    it.col_offset = CoordBits'($urandom_range(0, 4095));
    it.color      = $urandom;
    it.alpha      = AlphaW'($urandom_range(0, 255));
    it.layer      = LayerW'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic send_item(circle_item_t it);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= pack_item(it);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // a load followed by steps whose other fields carry random, ignored values
  task automatic send_circle(circle_item_t ld, int nsteps);
    send_item(ld);
    repeat (nsteps) send_item(rand_item(OP_STEP, 0, 4095));
  endtask

  // sender pauses until every expected pixel has come
  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pixel_q.size() != 0) @(posedge clk_i);
  endtask

  // steps from the reset state, before any circle is loaded
  task automatic test_step_before_load();
    send_item(rand_item(OP_STEP, 0, 4095));
    send_item(rand_item(OP_STEP, 0, 4095));
    drain_outputs();
  endtask

  // zero radius draws nothing
  task automatic test_zero_radius();
    send_circle(rand_item(OP_LOAD, 0, 0), 2);
    drain_outputs();
  endtask

  // radius one and two, including steps after the outline is done
  task automatic test_tiny_radii();
    send_circle(rand_item(OP_LOAD, 1, 1), 2);
    send_circle(rand_item(OP_LOAD, 2, 2), 3);
    drain_outputs();
  endtask

  // all-ones fields, then a circle at the origin with negative coordinates
  task automatic test_extreme_fields();
    circle_item_t it;
    it = '{OP_LOAD, '1, '1, '1, '1, '1, '1, '1, '1};
    send_circle(it, 3);
    it = '{OP_LOAD, '0, '0, 12'd5, '0, '0, '0, '0, '0};
    send_circle(it, 6);
    drain_outputs();
  endtask

  // long receiver hold-off while the sender keeps offering steps
  task automatic test_output_hold();
    hold_req++;
    send_circle(rand_item(OP_LOAD, 30, 40), 24);
    drain_outputs();
  endtask

  task automatic test_random_circles(int n_items);
    circle_item_t ld;
    int start;
    int pick;
    int nsteps;
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // well-formed circle, sometimes cut short by the next load
        ld     = rand_item(OP_LOAD, 1, 20);
        nsteps = ld.radius * 3 / 4 + $urandom_range(1, 3);
        if ($urandom_range(0, 6) == 0) nsteps = $urandom_range(1, nsteps);
        send_circle(ld, nsteps);
      end else if (pick < 82) begin
        send_circle(rand_item(OP_LOAD, 0, 4095), $urandom_range(1, 6));
      end else if (pick < 88) begin
        send_circle(rand_item(OP_LOAD, 0, 0), $urandom_range(1, 2));
      end else begin
        send_item(rand_item(opcode_e'($urandom_range(0, 1)), 0, 4095));
      end
      if ($urandom_range(0, 9) == 0) drain_outputs();
    end
    drain_outputs();
  endtask

  // back-to-back circles with no idling on either side
  task automatic test_streaming(int n_items);
    int start;
    start = items_sent;
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    while (items_sent - start < n_items) begin
      send_circle(rand_item(OP_LOAD, 1, 12), $urandom_range(2, 10));
    end
    drain_outputs();
  endtask

  // test sequence
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    test_step_before_load();
    test_zero_radius();
    test_tiny_radii();
    test_extreme_fields();
    test_output_hold();
    test_random_circles(200);
    test_streaming(40);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("tb_midpoint_circle_rasterizer_top passed");
    end else begin
      $display("tb_midpoint_circle_rasterizer_top failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/mcr_pkg.sv
hdl/mcr_walker.sv
hdl/mcr_emitter.sv
hdl/midpoint_circle_rasterizer_top.sv
tb/tb_midpoint_circle_rasterizer_top.sv
